// ===== sv/bcep_pkg.sv =====
// bcep_pkg: shared constants, word types and helpers for the ball circle exit predictor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package bcep_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ZSH        = 2 * FRAC_BITS + 1;
  localparam int SQ_STAGES  = 64;
  localparam int DIV_STAGES = 96;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 1'b1;

  localparam logic [30:0] RADIUS_RST  = 31'd85197;
  localparam logic [30:0] GRAVITY_RST = 31'd642908;

  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_VX_ZERO = 2'd2;

  localparam logic [46:0] TIME_LIMIT = 47'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
  } in_t;

  // Sideband carried through the square root.
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vxm;
    logic [31:0] vym;
    logic [31:0] vzm;
    logic        vxn;
    logic        vyn;
    logic        vzn;
    logic [63:0] d;
    logic [65:0] nq;
    logic        zero;
    logic        miss;
  } sq_side_t;

  // Sideband carried through the dividers.
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vzm;
    logic        vzn;
    logic        xneg;
    logic        yneg;
    logic        tneg;
    logic [63:0] d;
    logic        zero;
    logic        miss;
  } dv_side_t;

  typedef struct packed {
    logic [31:0] exit_x;
    logic [31:0] exit_y;
    logic [31:0] exit_z;
    logic [1:0]  status;
  } res_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [65:0] sext66(logic [63:0] p, logic n);
    return n ? (~{2'b00, p} + 66'd1) : {2'b00, p};
  endfunction

endpackage

// ===== sv/bcep_front.sv =====
// bcep_front: products, line-circle discriminant and miss detect (6 stages).
// Depends on bcep_pkg.
`timescale 1ns / 1ps
module bcep_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  bcep_pkg::in_t      in_data,
  input  logic [30:0]        radius,
  output logic               out_vld,
  output logic [127:0]       out_disc,
  output bcep_pkg::sq_side_t out_side
);
  import bcep_pkg::*;

  typedef struct packed {
    sq_side_t    side;
    logic [31:0] pxm;
    logic [31:0] pym;
    logic        pxn;
    logic        pyn;
  } s1_t;

  typedef struct packed {
    sq_side_t    side;
    logic [63:0] vx2;
    logic [63:0] vy2;
    logic [63:0] c1;
    logic [63:0] c2;
    logic [63:0] q1;
    logic [63:0] q2;
    logic        c1n;
    logic        c2n;
    logic        q1n;
    logic        q2n;
    logic [63:0] r2;
  } s2_t;

  typedef struct packed {
    sq_side_t    side;
    logic [63:0] c;
    logic [63:0] r2;
  } s3_t;

  typedef struct packed {
    sq_side_t    side;
    logic [63:0] a00;
    logic [63:0] a01;
    logic [63:0] a10;
    logic [63:0] a11;
    logic [63:0] b00;
    logic [63:0] b01;
    logic [63:0] b11;
  } s4_t;

  typedef struct packed {
    sq_side_t     side;
    logic [127:0] a;
    logic [127:0] b;
  } s5_t;

  typedef struct packed {
    sq_side_t     side;
    logic [127:0] disc;
  } s6_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  s6_t s6_r, s6_nxt;
  logic [5:0] vld_r;

  always_comb begin
    s1_nxt           = '0;
    s1_nxt.side.px   = in_data.px;
    s1_nxt.side.py   = in_data.py;
    s1_nxt.side.pz   = in_data.pz;
    s1_nxt.side.vxm  = mag32(in_data.vx);
    s1_nxt.side.vym  = mag32(in_data.vy);
    s1_nxt.side.vzm  = mag32(in_data.vz);
    s1_nxt.side.vxn  = in_data.vx[31];
    s1_nxt.side.vyn  = in_data.vy[31];
    s1_nxt.side.vzn  = in_data.vz[31];
    s1_nxt.side.zero = (in_data.vx == 32'd0);
    s1_nxt.pxm       = mag32(in_data.px);
    s1_nxt.pym       = mag32(in_data.py);
    s1_nxt.pxn       = in_data.px[31];
    s1_nxt.pyn       = in_data.py[31];
  end

  always_comb begin
    s2_nxt      = '0;
    s2_nxt.side = s1_r.side;
    s2_nxt.vx2  = s1_r.side.vxm * s1_r.side.vxm;
    s2_nxt.vy2  = s1_r.side.vym * s1_r.side.vym;
    s2_nxt.c1   = s1_r.side.vym * s1_r.pxm;
    s2_nxt.c2   = s1_r.side.vxm * s1_r.pym;
    s2_nxt.q1   = s1_r.pxm * s1_r.side.vxm;
    s2_nxt.q2   = s1_r.pym * s1_r.side.vym;
    s2_nxt.c1n  = s1_r.side.vyn ^ s1_r.pxn;
    s2_nxt.c2n  = s1_r.side.vxn ^ s1_r.pyn;
    s2_nxt.q1n  = s1_r.pxn ^ s1_r.side.vxn;
    s2_nxt.q2n  = s1_r.pyn ^ s1_r.side.vyn;
    s2_nxt.r2   = radius * radius;
  end

  // cross term magnitude and negated dot product
  always_comb begin
    logic [65:0] cd;
    logic [65:0] cabs;
    logic [65:0] qs;
    cd             = sext66(s2_r.c1, s2_r.c1n) - sext66(s2_r.c2, s2_r.c2n);
    cabs           = cd[65] ? (~cd + 66'd1) : cd;
    qs             = sext66(s2_r.q1, s2_r.q1n) + sext66(s2_r.q2, s2_r.q2n);
    s3_nxt         = '0;
    s3_nxt.side    = s2_r.side;
    s3_nxt.side.d  = s2_r.vx2 + s2_r.vy2;
    s3_nxt.side.nq = ~qs + 66'd1;
    s3_nxt.c       = cabs[63:0];
    s3_nxt.r2      = s2_r.r2;
  end

  always_comb begin
    s4_nxt      = '0;
    s4_nxt.side = s3_r.side;
    s4_nxt.a00  = s3_r.r2[31:0]  * s3_r.side.d[31:0];
    s4_nxt.a01  = s3_r.r2[31:0]  * s3_r.side.d[63:32];
    s4_nxt.a10  = s3_r.r2[63:32] * s3_r.side.d[31:0];
    s4_nxt.a11  = s3_r.r2[63:32] * s3_r.side.d[63:32];
    s4_nxt.b00  = s3_r.c[31:0]   * s3_r.c[31:0];
    s4_nxt.b01  = s3_r.c[31:0]   * s3_r.c[63:32];
    s4_nxt.b11  = s3_r.c[63:32]  * s3_r.c[63:32];
  end

  always_comb begin
    s5_nxt.side = s4_r.side;
    s5_nxt.a    = {s4_r.a11, 64'd0} + {32'd0, s4_r.a01, 32'd0}
                + {32'd0, s4_r.a10, 32'd0} + {64'd0, s4_r.a00};
    s5_nxt.b    = {s4_r.b11, 64'd0} + {31'd0, s4_r.b01, 33'd0} + {64'd0, s4_r.b00};
  end

  always_comb begin
    s6_nxt           = '0;
    s6_nxt.side      = s5_r.side;
    s6_nxt.side.miss = (s5_r.a < s5_r.b);
    s6_nxt.disc      = s5_r.a - s5_r.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
    end
  end

  assign out_vld  = vld_r[5];
  assign out_disc = s6_r.disc;
  assign out_side = s6_r.side;

endmodule

// ===== sv/bcep_sqrt.sv =====
// bcep_sqrt: pipelined integer square root, two radicand bits per stage.
// Depends on bcep_pkg (SQ_STAGES, sq_side_t).
`timescale 1ns / 1ps
module bcep_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [127:0]       in_disc,
  input  bcep_pkg::sq_side_t in_side,
  output logic               out_vld,
  output logic [63:0]        out_root,
  output bcep_pkg::sq_side_t out_side
);
  import bcep_pkg::*;

  typedef struct packed {
    logic [65:0]  rem;
    logic [63:0]  root;
    logic [127:0] val;
  } sq_t;

  function automatic sq_t sq_step(sq_t p);
    logic [67:0] cur;
    logic [67:0] trial;
    sq_t         n;
    cur   = {p.rem, p.val[127:126]};
    trial = {2'b00, p.root, 2'b01};
    n.val = p.val << 2;
    if (cur >= trial) begin
      n.rem  = 66'(cur - trial);
      n.root = {p.root[62:0], 1'b1};
    end else begin
      n.rem  = cur[65:0];
      n.root = {p.root[62:0], 1'b0};
    end
    return n;
  endfunction

  sq_t      prv_st  [SQ_STAGES];
  sq_t      st_nxt  [SQ_STAGES];
  sq_t      st_r    [SQ_STAGES];
  sq_side_t prv_side[SQ_STAGES];
  sq_side_t side_r  [SQ_STAGES];
  logic [SQ_STAGES-1:0] vld_r;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
    if (k == 0) begin : g_first
      assign prv_st[k]   = '{rem: '0, root: '0, val: in_disc};
      assign prv_side[k] = in_side;
    end else begin : g_next
      assign prv_st[k]   = st_r[k-1];
      assign prv_side[k] = side_r[k-1];
    end
    assign st_nxt[k] = sq_step(prv_st[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        st_r[k]   <= st_nxt[k];
        side_r[k] <= prv_side[k];
      end
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_root = st_r[SQ_STAGES-1].root;
  assign out_side = side_r[SQ_STAGES-1];

endmodule

// ===== sv/bcep_div.sv =====
// bcep_div: root selection, numerator products and three lockstep restoring dividers.
// Depends on bcep_pkg (DIV_STAGES, FRAC_BITS, side types).
`timescale 1ns / 1ps
module bcep_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [63:0]        in_root,
  input  bcep_pkg::sq_side_t in_side,
  output logic               out_vld,
  output logic [95:0]        out_qx,
  output logic [95:0]        out_qy,
  output logic [95:0]        out_qt,
  output bcep_pkg::dv_side_t out_side
);
  import bcep_pkg::*;

  typedef struct packed {
    sq_side_t    side;
    logic [63:0] ntm;
    logic        ntneg;
  } p1_t;

  typedef struct packed {
    sq_side_t    side;
    logic [63:0] ntm;
    logic        ntneg;
    logic [63:0] xl;
    logic [63:0] xh;
    logic [63:0] yl;
    logic [63:0] yh;
  } p2_t;

  typedef struct packed {
    dv_side_t    side;
    logic [95:0] nx;
    logic [95:0] ny;
    logic [95:0] nt;
  } p3_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [95:0] q;
  } dl_t;

  typedef struct packed {
    dl_t x;
    dl_t y;
    dl_t t;
  } dv_t;

  function automatic dl_t div_step(dl_t p, logic [63:0] d);
    logic [64:0] cur;
    logic        ge;
    dl_t         n;
    cur   = {p.rem, p.q[95]};
    ge    = (cur >= {1'b0, d});
    n.rem = ge ? 64'(cur - {1'b0, d}) : cur[63:0];
    n.q   = {p.q[94:0], ge};
    return n;
  endfunction

  p1_t p1_r, p1_nxt;
  p2_t p2_r, p2_nxt;
  p3_t p3_r, p3_nxt;
  logic [2:0] pv_r;

  // pick the crossing ahead of the ball along x
  always_comb begin
    logic [65:0] nlo;
    logic [65:0] nhi;
    logic [65:0] nt;
    logic        lo_pos;
    logic        hi_pos;
    nlo    = in_side.nq - {2'b00, in_root};
    nhi    = in_side.nq + {2'b00, in_root};
    lo_pos = !nlo[65] && (nlo != 66'd0);
    hi_pos = !nhi[65] && (nhi != 66'd0);
    if (!in_side.vxn) begin
      nt = lo_pos ? nlo : nhi;
    end else begin
      nt = hi_pos ? nhi : nlo;
    end
    p1_nxt.side  = in_side;
    p1_nxt.ntneg = nt[65];
    p1_nxt.ntm   = nt[65] ? 64'(~nt + 66'd1) : nt[63:0];
  end

  always_comb begin
    p2_nxt.side  = p1_r.side;
    p2_nxt.ntm   = p1_r.ntm;
    p2_nxt.ntneg = p1_r.ntneg;
    p2_nxt.xl    = p1_r.ntm[31:0]  * p1_r.side.vxm;
    p2_nxt.xh    = p1_r.ntm[63:32] * p1_r.side.vxm;
    p2_nxt.yl    = p1_r.ntm[31:0]  * p1_r.side.vym;
    p2_nxt.yh    = p1_r.ntm[63:32] * p1_r.side.vym;
  end

  always_comb begin
    p3_nxt.side.px   = p2_r.side.px;
    p3_nxt.side.py   = p2_r.side.py;
    p3_nxt.side.pz   = p2_r.side.pz;
    p3_nxt.side.vzm  = p2_r.side.vzm;
    p3_nxt.side.vzn  = p2_r.side.vzn;
    p3_nxt.side.xneg = p2_r.ntneg ^ p2_r.side.vxn;
    p3_nxt.side.yneg = p2_r.ntneg ^ p2_r.side.vyn;
    p3_nxt.side.tneg = p2_r.ntneg;
    p3_nxt.side.d    = p2_r.side.d;
    p3_nxt.side.zero = p2_r.side.zero;
    p3_nxt.side.miss = p2_r.side.miss;
    p3_nxt.nx        = {p2_r.xh, 32'd0} + {32'd0, p2_r.xl};
    p3_nxt.ny        = {p2_r.yh, 32'd0} + {32'd0, p2_r.yl};
    p3_nxt.nt        = 96'(p2_r.ntm) << FRAC_BITS;
  end

  dv_t      prv_st  [DIV_STAGES];
  dv_t      st_nxt  [DIV_STAGES];
  dv_t      st_r    [DIV_STAGES];
  dv_side_t prv_side[DIV_STAGES];
  dv_side_t side_r  [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    if (k == 0) begin : g_first
      assign prv_st[k].x  = '{rem: '0, q: p3_r.nx};
      assign prv_st[k].y  = '{rem: '0, q: p3_r.ny};
      assign prv_st[k].t  = '{rem: '0, q: p3_r.nt};
      assign prv_side[k]  = p3_r.side;
    end else begin : g_next
      assign prv_st[k]   = st_r[k-1];
      assign prv_side[k] = side_r[k-1];
    end
    assign st_nxt[k].x = div_step(prv_st[k].x, prv_side[k].d);
    assign st_nxt[k].y = div_step(prv_st[k].y, prv_side[k].d);
    assign st_nxt[k].t = div_step(prv_st[k].t, prv_side[k].d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= '0;
      vld_r <= '0;
    end else if (en) begin
      pv_r  <= {pv_r[1:0], in_vld};
      vld_r <= {vld_r[DIV_STAGES-2:0], pv_r[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_r[k]   <= st_nxt[k];
        side_r[k] <= prv_side[k];
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_qx   = st_r[DIV_STAGES-1].x.q;
  assign out_qy   = st_r[DIV_STAGES-1].y.q;
  assign out_qt   = st_r[DIV_STAGES-1].t.q;
  assign out_side = side_r[DIV_STAGES-1];

endmodule

// ===== sv/bcep_back.sv =====
// bcep_back: exit x/y, time clamp, ballistic height, saturation and status (7 stages).
// Depends on bcep_pkg.
`timescale 1ns / 1ps
module bcep_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [95:0]        in_qx,
  input  logic [95:0]        in_qy,
  input  logic [95:0]        in_qt,
  input  bcep_pkg::dv_side_t in_side,
  input  logic [30:0]        gravity,
  output logic               out_vld,
  output bcep_pkg::res_t     out_res
);
  import bcep_pkg::*;

  typedef struct packed {
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] pz;
    logic        zero;
    logic        miss;
  } base_t;

  typedef struct packed {
    base_t       b;
    logic [31:0] vzm;
    logic        vzn;
    logic        tneg;
    logic [46:0] tmag;
  } b1_t;

  typedef struct packed {
    base_t       b;
    logic        tn;
    logic [63:0] vt0;
    logic [46:0] vt1;
    logic [63:0] tt00;
    logic [46:0] tt01;
    logic [29:0] tt11;
  } b2_t;

  typedef struct packed {
    base_t       b;
    logic        tn;
    logic [78:0] term;
    logic [93:0] tt;
  } b3_t;

  typedef struct packed {
    base_t       b;
    logic        tn;
    logic [78:0] term;
    logic [63:0] g0;
    logic [63:0] g1;
    logic [63:0] g2;
  } b4_t;

  typedef struct packed {
    base_t        b;
    logic         tn;
    logic [78:0]  term;
    logic [127:0] gt;
  } b5_t;

  typedef struct packed {
    base_t        b;
    logic [127:0] acc;
  } b6_t;

  function automatic logic [31:0] sat128(logic [127:0] a);
    if (!a[127] && (a[126:31] != '0)) begin
      return 32'h7FFF_FFFF;
    end else if (a[127] && (a[126:31] != '1)) begin
      return 32'h8000_0000;
    end
    return a[31:0];
  endfunction

  function automatic logic [127:0] add_q(logic [31:0] p, logic [95:0] q, logic n);
    logic [127:0] qe;
    qe = {32'd0, q};
    return {{96{p[31]}}, p} + (n ? (~qe + 128'd1) : qe);
  endfunction

  b1_t b1_r, b1_nxt;
  b2_t b2_r, b2_nxt;
  b3_t b3_r, b3_nxt;
  b4_t b4_r, b4_nxt;
  b5_t b5_r, b5_nxt;
  b6_t b6_r, b6_nxt;
  res_t res_r, res_nxt;
  logic [6:0] vld_r;

  always_comb begin
    b1_nxt.b.ex   = sat128(add_q(in_side.px, in_qx, in_side.xneg));
    b1_nxt.b.ey   = sat128(add_q(in_side.py, in_qy, in_side.yneg));
    b1_nxt.b.pz   = in_side.pz;
    b1_nxt.b.zero = in_side.zero;
    b1_nxt.b.miss = in_side.miss;
    b1_nxt.vzm    = in_side.vzm;
    b1_nxt.vzn    = in_side.vzn;
    b1_nxt.tneg   = in_side.tneg;
    b1_nxt.tmag   = (in_qt > 96'(TIME_LIMIT)) ? TIME_LIMIT : in_qt[46:0];
  end

  always_comb begin
    b2_nxt.b    = b1_r.b;
    b2_nxt.tn   = b1_r.vzn ^ b1_r.tneg;
    b2_nxt.vt0  = b1_r.vzm * b1_r.tmag[31:0];
    b2_nxt.vt1  = b1_r.vzm * b1_r.tmag[46:32];
    b2_nxt.tt00 = b1_r.tmag[31:0]  * b1_r.tmag[31:0];
    b2_nxt.tt01 = b1_r.tmag[31:0]  * b1_r.tmag[46:32];
    b2_nxt.tt11 = b1_r.tmag[46:32] * b1_r.tmag[46:32];
  end

  always_comb begin
    b3_nxt.b    = b2_r.b;
    b3_nxt.tn   = b2_r.tn;
    b3_nxt.term = {b2_r.vt1, 32'd0} + {15'd0, b2_r.vt0};
    b3_nxt.tt   = {b2_r.tt11, 64'd0} + {14'd0, b2_r.tt01, 33'd0} + {30'd0, b2_r.tt00};
  end

  always_comb begin
    b4_nxt.b    = b3_r.b;
    b4_nxt.tn   = b3_r.tn;
    b4_nxt.term = b3_r.term;
    b4_nxt.g0   = b3_r.tt[31:0]  * gravity;
    b4_nxt.g1   = b3_r.tt[63:32] * gravity;
    b4_nxt.g2   = b3_r.tt[93:64] * gravity;
  end

  always_comb begin
    b5_nxt.b    = b4_r.b;
    b5_nxt.tn   = b4_r.tn;
    b5_nxt.term = b4_r.term;
    b5_nxt.gt   = {b4_r.g2, 64'd0} + {32'd0, b4_r.g1, 32'd0} + {64'd0, b4_r.g0};
  end

  // 2^(2F+1)*pz +- 2^(F+1)*vz*t - g*t*t
  always_comb begin
    logic [127:0] pzs;
    logic [127:0] tsh;
    pzs        = {{96{b5_r.b.pz[31]}}, b5_r.b.pz} << ZSH;
    tsh        = 128'(b5_r.term) << (FRAC_BITS + 1);
    b6_nxt.b   = b5_r.b;
    b6_nxt.acc = pzs + (b5_r.tn ? (~tsh + 128'd1) : tsh) - b5_r.gt;
  end

  always_comb begin
    logic [127:0] zs;
    zs = $signed(b6_r.acc) >>> ZSH;
    if (b6_r.b.zero) begin
      res_nxt = '{exit_x: '0, exit_y: '0, exit_z: '0, status: ST_VX_ZERO};
    end else if (b6_r.b.miss) begin
      res_nxt = '{exit_x: '0, exit_y: '0, exit_z: '0, status: ST_MISS};
    end else begin
      res_nxt = '{exit_x: b6_r.b.ex, exit_y: b6_r.b.ey, exit_z: sat128(zs),
                  status: ST_VALID};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r  <= b1_nxt;
      b2_r  <= b2_nxt;
      b3_r  <= b3_nxt;
      b4_r  <= b4_nxt;
      b5_r  <= b5_nxt;
      b6_r  <= b6_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_vld = vld_r[6];
  assign out_res = res_r;

endmodule

// ===== sv/ball_circle_exit_predictor.sv =====
// ball_circle_exit_predictor: top level, config registers, pipeline and output register.
// Depends on bcep_pkg, bcep_front, bcep_sqrt, bcep_div, bcep_back.
//
// Usage:
//   in_*  : one word per ball sample, six signed Q16.16 fields in tdata.
//   out_* : one word per sample: exit x/y/z in tdata, status in tuser
//           (valid, line misses circle, x velocity zero; zeros on the last two).
//   cfg_* : write-only port for circle radius (index 0) and gravity (index 1),
//           31-bit values; write only while no sample is in flight.
// Pipeline: 177 register stages (6 front, 64 square root, 3 + 96 divider,
//   7 back, 1 output).
// Throughput: one word per cycle when not stalled; the square root retires two
//   radicand bits a stage, the dividers one quotient bit a stage, all fully pipelined.
// Stall: when the output word is held (out_tready low) the whole pipeline
//   freezes and in_tready drops; nothing is dropped or duplicated.
// Reset: rst_n (synchronous, active low) clears all valid bits and loads the
//   default radius (1.3 m) and gravity (9.81 m/s^2).
`timescale 1ns / 1ps
module ball_circle_exit_predictor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each, lowest first)
  input  logic [191:0]                     in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // exit_x, exit_y, exit_z (32 bits each, lowest first)
  output logic [95:0]                      out_tdata,
  // status
  output logic [1:0]                       out_tuser,
  input  logic                             cfg_wr_en,
  input  logic [bcep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [30:0]                      cfg_wdata
);
  import bcep_pkg::*;

  logic [30:0] radius_r;
  logic [30:0] gravity_r;
  logic        en;

  in_t      in_data;
  logic     fr_vld;
  logic [127:0] fr_disc;
  sq_side_t fr_side;
  logic     sq_vld;
  logic [63:0] sq_root;
  sq_side_t sq_side;
  logic     dv_vld;
  logic [95:0] dv_qx;
  logic [95:0] dv_qy;
  logic [95:0] dv_qt;
  dv_side_t dv_side;
  logic     bk_vld;
  res_t     bk_res;

  logic     out_vld_r;
  res_t     out_res_r;

  // whole pipeline moves together; it holds only when the output word is stuck
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  assign in_data.px = in_tdata[31:0];
  assign in_data.py = in_tdata[63:32];
  assign in_data.pz = in_tdata[95:64];
  assign in_data.vx = in_tdata[127:96];
  assign in_data.vy = in_tdata[159:128];
  assign in_data.vz = in_tdata[191:160];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RADIUS_RST;
      gravity_r <= GRAVITY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RADIUS:  radius_r  <= cfg_wdata;
        REG_GRAVITY: gravity_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bcep_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .in_data  (in_data),
    .radius   (radius_r),
    .out_vld  (fr_vld),
    .out_disc (fr_disc),
    .out_side (fr_side)
  );

  bcep_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_disc  (fr_disc),
    .in_side  (fr_side),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  bcep_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_vld),
    .in_root  (sq_root),
    .in_side  (sq_side),
    .out_vld  (dv_vld),
    .out_qx   (dv_qx),
    .out_qy   (dv_qy),
    .out_qt   (dv_qt),
    .out_side (dv_side)
  );

  bcep_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (dv_vld),
    .in_qx    (dv_qx),
    .in_qy    (dv_qy),
    .in_qt    (dv_qt),
    .in_side  (dv_side),
    .gravity  (gravity_r),
    .out_vld  (bk_vld),
    .out_res  (bk_res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= bk_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= bk_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_res_r.exit_z, out_res_r.exit_y, out_res_r.exit_x};
  assign out_tuser  = out_res_r.status;

endmodule

// ===== bench/bcep_exit_checker.sv =====
// bcep_exit_checker: watches the input and result streams of the ball circle exit predictor,
// computes each expected exit word and compares it field by field. Depends on bcep_pkg.
`timescale 1ns / 1ps
module bcep_exit_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tready,
  input  logic [191:0]  in_tdata,
  input  logic          out_tvalid,
  input  logic          out_tready,
  input  logic [95:0]   out_tdata,
  input  logic [1:0]    out_tuser,
  input  logic          cfg_wr_en,
  input  logic [bcep_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [30:0]   cfg_wdata,
  output int            fail_count,
  output int            pending
);
  import bcep_pkg::*;

  typedef struct {
    logic [31:0] ex, ey, ez;
    logic [1:0]  st;
  } exit_word_t;

  logic [30:0] radius_q, gravity_q;
  exit_word_t exit_q[$];

  function automatic logic signed [31:0] sat32(logic signed [255:0] v);
    if (v > 256'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -256'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] v);
    logic [127:0] res;
    logic [127:0] c;
    res = 0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (128'd1 << b);
      if (c * c <= v) res = c;
    end
    return res;
  endfunction

  // Exact-width math: 256-bit signed holds every intermediate.
  function automatic exit_word_t predict_exit(logic [191:0] w);
    logic signed [255:0] px, py, pz, vx, vy, vz, d, c, disc, s, nq, nlo, nhi, n, t, acc, g;
    logic signed [255:0] tm, r;
    exit_word_t e;
    px = $signed(w[31:0]);    py = $signed(w[63:32]);   pz = $signed(w[95:64]);
    vx = $signed(w[127:96]);  vy = $signed(w[159:128]); vz = $signed(w[191:160]);
    e.ex = 0; e.ey = 0; e.ez = 0;
    if (vx == 0) begin
      e.st = ST_VX_ZERO;
      return e;
    end
    r = radius_q;
    g = gravity_q;
    d = vx * vx + vy * vy;
    c = vy * px - vx * py;
    disc = r * r * d - c * c;
    if (disc < 0) begin
      e.st = ST_MISS;
      return e;
    end
    s = isqrt(disc[127:0]);
    nq = -(px * vx + py * vy);
    nlo = nq - s;
    nhi = nq + s;
    if (vx > 0) n = (nlo > 0) ? nlo : nhi;
    else n = (nhi > 0) ? nhi : nlo;
    // SV signed division truncates toward zero
    e.ex = sat32(px + (vx * n) / d);
    e.ey = sat32(py + (vy * n) / d);
    tm = ((n < 0 ? -n : n) <<< FRAC_BITS) / d;
    if (tm > $signed({209'd0, TIME_LIMIT})) tm = $signed({209'd0, TIME_LIMIT});
    t = (n < 0) ? -tm : tm;
    acc = (pz <<< ZSH) + ((vz * t) <<< (FRAC_BITS + 1)) - g * tm * tm;
    e.ez = sat32(acc >>> ZSH);
    e.st = ST_VALID;
    return e;
  endfunction

  assign pending = exit_q.size();

  always @(posedge clk) begin
    exit_word_t exp_w;
    if (!rst_n) begin
      radius_q <= RADIUS_RST;
      gravity_q <= GRAVITY_RST;
      fail_count <= 0;
      exit_q.delete();
    end else begin
      if (cfg_wr_en && cfg_index == REG_RADIUS) radius_q <= cfg_wdata;
      if (cfg_wr_en && cfg_index == REG_GRAVITY) gravity_q <= cfg_wdata;
      if (in_tvalid && in_tready) exit_q.push_back(predict_exit(in_tdata));
      if (out_tvalid && out_tready) begin
        if (exit_q.size() == 0) begin
          $display("%0t: unexpected word x=%h y=%h z=%h st=%0d", $time,
                   out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = exit_q.pop_front();
          if (exp_w.ex !== out_tdata[31:0] || exp_w.ey !== out_tdata[63:32] ||
              exp_w.ez !== out_tdata[95:64] || exp_w.st !== out_tuser) begin
            $display("%0t: mismatch exp x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
                     $time, exp_w.ex, exp_w.ey, exp_w.ez, exp_w.st,
                     out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== bench/tb_ball_circle_exit_predictor.sv =====
// tb_ball_circle_exit_predictor: stimulus and verdict for the ball circle exit predictor.
// Depends on bcep_pkg, ball_circle_exit_predictor and bcep_exit_checker.
`timescale 1ns / 1ps
module tb_ball_circle_exit_predictor;
  import bcep_pkg::*;

  localparam int LATENCY = 176;
  localparam int Q1 = 65536;   // 1.0 in Q16.16

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_wr_en;
  logic [191:0] in_tdata;
  logic [95:0] out_tdata;
  logic [1:0] out_tuser;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [30:0] cfg_wdata;
  int fail_count, pending;
  int send_idle_pct, recv_stall_pct;

  ball_circle_exit_predictor dut (.*);

  bcep_exit_checker chk (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Receiver: random back-pressure per phase, decided at each falling edge.
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // One word on the input stream, with a random idle gap in front.
  task automatic send_sample(input logic [31:0] px, py, pz, vx, vy, vz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {vz, vy, vx, pz, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_coord();
    // mostly near the circle, sometimes anything
    case ($urandom_range(3))
      0: return $urandom();
      default: return $urandom_range(8 * Q1) - 4 * Q1;
    endcase
  endfunction

  function automatic logic [31:0] rnd_vel();
    case ($urandom_range(7))
      0: return $urandom();
      1: return 32'd0;
      2: return $urandom_range(3) - 1;
      default: return $urandom_range(40 * Q1) - 20 * Q1;
    endcase
  endfunction

  task automatic random_block(input int n);
    for (int i = 0; i < n; i++)
      send_sample(rnd_coord(), rnd_coord(), rnd_coord(), rnd_vel(), rnd_vel(), rnd_vel());
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_RADIUS;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset radius and gravity.
    send_sample(0, 0, Q1, Q1, 0, 0);                      // straight out along +x
    send_sample(0, 0, Q1, -Q1, 0, 0);                     // along -x
    send_sample(Q1, 0, 0, 0, Q1, 0);                      // zero x velocity
    send_sample(0, 5 * Q1, 0, Q1, 0, 0);                  // misses the circle
    send_sample(0, 85197, 0, Q1, 0, Q1);                  // tangent at the top
    send_sample(5 * Q1, 0, 0, Q1, 0, 0);                  // outside, moving away
    send_sample(-5 * Q1, 0, 0, Q1, Q1 / 8, 3 * Q1);       // outside, moving in
    send_sample(0, 0, 0, 1, 0, 32'h8000_0000);            // very slow: long flight
    send_sample(0, 0, 32'h7FFF_FFFF, -1, 1, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(Q1 / 2, -Q1 / 3, 2 * Q1, 3 * Q1, -2 * Q1, 4 * Q1);
    drain_and_settle();

    // Extremes of both registers.
    write_reg(REG_RADIUS, 31'd0);
    write_reg(REG_GRAVITY, 31'd0);
    send_sample(0, 0, Q1, Q1, 0, Q1);                     // zero radius: tangent at origin
    send_sample(Q1, 0, Q1, -Q1, Q1, Q1);
    send_sample(0, Q1, Q1, Q1, 0, Q1);
    drain_and_settle();
    write_reg(REG_RADIUS, 31'h7FFF_FFFF);
    write_reg(REG_GRAVITY, 31'h7FFF_FFFF);
    send_sample(0, 0, 0, Q1, Q1, Q1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1);
    send_sample(1, 1, 1, 1, 1, 1);
    drain_and_settle();

    // Random phases: idling profile x register setting.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      case (ph)
        0: begin write_reg(REG_RADIUS, RADIUS_RST); write_reg(REG_GRAVITY, GRAVITY_RST); end
        3: write_reg(REG_RADIUS, 31'($urandom_range(10 * Q1)));
        5: write_reg(REG_GRAVITY, 31'($urandom()));
        6: write_reg(REG_RADIUS, 31'($urandom()));
        default: ;
      endcase
      random_block(115);
      drain_and_settle();
    end

    if (fail_count == 0) $display("PASS ball_circle_exit_predictor");
    else $display("FAIL ball_circle_exit_predictor");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL ball_circle_exit_predictor");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/bcep_pkg.sv
sv/bcep_front.sv
sv/bcep_sqrt.sv
sv/bcep_div.sv
sv/bcep_back.sv
sv/ball_circle_exit_predictor.sv
bench/bcep_exit_checker.sv
bench/tb_ball_circle_exit_predictor.sv
